// ----- rtl/pps_pkg.sv -----
// pps_pkg: shared types and constants for the prime sieve block
// no dependencies
package pps_pkg;

  // controller states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_READ  = 6'b000100,
    S_DIV   = 6'b001000,
    S_CHECK = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take_item;    // latch candidate and start the filter scan
    logic rd_filter;    // read next filter from store
    logic div_start;    // load divider with current filter
    logic div_step;     // one remainder bit
    logic next_filter;  // advance filter index
    logic mark_comp;    // record that the candidate is composite
    logic finish;       // form result and update the store
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_range;     // candidate in 2..limit
    logic scan_done;    // no filters left to test
    logic div_done;     // remainder complete
    logic divides;      // remainder zero, filter usable
  } stat_t;

endpackage

// ----- rtl/pipelined_prime_sieve_top.sv -----
// pipelined_prime_sieve_top: candidate in, prime verdict out
// after accept, each stored filter is read and run through the bit-serial remainder
// unit in turn; the scan stops at the first filter that divides
// one candidate at a time, next can be taken in the cycle after its result is formed
// synchronous active-high reset empties the filter store, limit = 2
module pipelined_prime_sieve_top #(
  parameter int MAX_FILTERS = 512,
  parameter int VALUE_BITS  = 22
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [VALUE_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] candidate,
  input  logic                  end_of_run,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] tested_value,
  output logic                  is_prime,
  output logic                  last_result
);
  import pps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pps_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  pps_datapath #(.MAX_FILTERS(MAX_FILTERS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_data, .candidate, .end_of_run,
    .tested_value, .is_prime, .last_result
  );
endmodule

// ----- rtl/pps_datapath.sv -----
// pps_datapath: filter store, bit-serial remainder unit, result register
// depends on pps_pkg
module pps_datapath #(
  parameter int MAX_FILTERS = 512,
  parameter int VALUE_BITS  = 22
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pps_pkg::cmd_t         cmd,
  output pps_pkg::stat_t        stat,
  input  logic                  cfg_we,
  input  logic [VALUE_BITS-1:0] cfg_data,
  input  logic [VALUE_BITS-1:0] candidate,
  input  logic                  end_of_run,
  output logic [VALUE_BITS-1:0] tested_value,
  output logic                  is_prime,
  output logic                  last_result
);
  import pps_pkg::*;

  localparam int IDX_BITS = $clog2(MAX_FILTERS);
  localparam int CNT_BITS = $clog2(MAX_FILTERS + 1);
  localparam int BIT_BITS = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] upper_limit;
  logic [VALUE_BITS-1:0] cand;
  logic                  last;
  logic                  composite;
  logic [CNT_BITS-1:0]   filter_count;
  logic [CNT_BITS-1:0]   scan_idx;
  logic [VALUE_BITS-1:0] filter_mem [MAX_FILTERS];
  logic [VALUE_BITS-1:0] filter_rd;
  logic [VALUE_BITS-1:0] divisor;
  logic [VALUE_BITS:0]   rem;
  logic [VALUE_BITS-1:0] shreg;
  logic [BIT_BITS-1:0]   bit_cnt;
  logic [2*VALUE_BITS-1:0] square;
  logic [VALUE_BITS:0]   rem_sh;
  logic                  usable;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= VALUE_BITS'(2);
    end else if (cfg_we) begin
      upper_limit <= cfg_data;
    end
  end

  // filter store
  always_ff @(posedge clk) begin
    if (cmd.finish && !composite && stat.in_range &&
        square <= {{VALUE_BITS{1'b0}}, upper_limit} &&
        filter_count < CNT_BITS'(MAX_FILTERS)) begin
      filter_mem[filter_count[IDX_BITS-1:0]] <= cand;
    end
    if (cmd.rd_filter) begin
      filter_rd <= filter_mem[scan_idx[IDX_BITS-1:0]];
    end
  end

  assign square = cand * cand;

  // candidate, scan index, fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count <= '0;
      scan_idx     <= '0;
      composite    <= 1'b0;
    end else begin
      if (cmd.take_item) begin
        scan_idx  <= '0;
        composite <= 1'b0;
      end
      if (cmd.next_filter) scan_idx <= scan_idx + 1'b1;
      if (cmd.mark_comp)   composite <= 1'b1;
      if (cmd.finish) begin
        if (last) begin
          filter_count <= '0;
        end else if (!composite && stat.in_range &&
                     square <= {{VALUE_BITS{1'b0}}, upper_limit} &&
                     filter_count < CNT_BITS'(MAX_FILTERS)) begin
          filter_count <= filter_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      cand <= candidate;
      last <= end_of_run;
    end
  end

  // restoring remainder, one bit per cycle
  assign rem_sh = {rem[VALUE_BITS-1:0], shreg[VALUE_BITS-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (cmd.div_start) begin
      divisor <= filter_rd;
      shreg   <= cand;
      rem     <= '0;
      bit_cnt <= BIT_BITS'(VALUE_BITS);
    end else if (cmd.div_step) begin
      shreg   <= shreg << 1;
      rem     <= (rem_sh >= {1'b0, divisor}) ? rem_sh - {1'b0, divisor} : rem_sh;
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

  assign usable = (divisor != '0) && (divisor < cand);

  assign stat.in_range  = (cand >= VALUE_BITS'(2)) && (cand <= upper_limit);
  assign stat.scan_done = (scan_idx >= filter_count);
  assign stat.div_done  = (bit_cnt == '0);
  assign stat.divides   = usable && (rem == '0);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      tested_value <= cand;
      is_prime     <= stat.in_range && !composite;
      last_result  <= last;
    end
  end
endmodule

// ----- rtl/pps_ctrl.sv -----
// pps_ctrl: sequencing state machine for the prime sieve
// depends on pps_pkg
module pps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pps_pkg::stat_t stat,
  output pps_pkg::cmd_t  cmd
);
  import pps_pkg::*;

  state_t state, state_next;
  logic   out_full, out_full_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next    = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!stat.in_range || stat.scan_done) begin
          state_next = S_CHECK;
        end else begin
          cmd.rd_filter = 1'b1;
          state_next    = S_READ;
        end
      end
      S_READ: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.next_filter = 1'b1;
          if (stat.divides) begin
            cmd.mark_comp = 1'b1;
            state_next    = S_CHECK;
          end else begin
            state_next = S_LOAD;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CHECK: begin
        if (!out_full || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register occupancy
  always_comb begin
    out_full_next = out_full;
    if (out_full && out_ready) out_full_next = 1'b0;
    if (cmd.finish)            out_full_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_full;
endmodule

// ----- rtl/pps_checker.sv -----
// pps_checker: port-level checks for the prime sieve
// depends on pipelined_prime_sieve_top ports
module pps_checker #(
  parameter int VALUE_BITS = 22
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] tested_value,
  input logic                  is_prime
);
  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tested_value) && $stable(is_prime))
    else $error("result changed while stalled");
  // a transaction is never accepted right after another
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back to back accept");
  // numbers below 2 are never prime
  a_small: assert property (@(posedge clk) disable iff (rst)
    out_valid && tested_value < VALUE_BITS'(2) |-> !is_prime)
    else $error("small value reported prime");
  // nothing shows right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind pipelined_prime_sieve_top pps_checker #(.VALUE_BITS(VALUE_BITS)) u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .tested_value, .is_prime
);
